// ===== sv/lbz_pkg.sv =====
// shared types and constants for the lorentz boost and interval unit
`default_nettype none
package lbz_pkg;

	localparam int DEF_WORD_BITS = 32;
	localparam int DEF_FRAC_BITS = 16;

	typedef logic [1:0] kind_t;

	// class of the input four-vector
	localparam kind_t KIND_TIMELIKE  = 2'd0;
	localparam kind_t KIND_LIGHTLIKE = 2'd1;
	localparam kind_t KIND_SPACELIKE = 2'd2;

endpackage
`default_nettype wire

// ===== sv/lbz_isqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none
module lbz_isqrt #(
	parameter int R_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*R_W-1:0]    radicand,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [R_W-1:0]      root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int IN_W  = 2 * R_W;
	localparam int REM_W = R_W + 3;

	logic [REM_W-1:0]  rem_r  [1:R_W-1];
	logic [IN_W-1:0]   src_r  [1:R_W-1];
	logic [R_W-1:0]    root_r [1:R_W];
	logic [SIDE_W-1:0] side_r [1:R_W];
	logic              vld_r  [1:R_W];

	for (genvar k = 0; k < R_W; k++) begin : g_step
		logic [REM_W-1:0]  cur_rem;
		logic [IN_W-1:0]   cur_src;
		logic [R_W-1:0]    cur_root;
		logic [SIDE_W-1:0] cur_side;
		logic              cur_vld;
		logic [REM_W-1:0]  sh;
		logic [REM_W-1:0]  trial;
		logic              ge;
		logic [REM_W-1:0]  nrem;
		logic [R_W-1:0]    nroot;

		if (k == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_src  = radicand;
			assign cur_root = '0;
			assign cur_side = in_side;
			assign cur_vld  = in_valid;
		end else begin : g_next
			assign cur_rem  = rem_r[k];
			assign cur_src  = src_r[k];
			assign cur_root = root_r[k];
			assign cur_side = side_r[k];
			assign cur_vld  = vld_r[k];
		end

		// bring down the next two radicand bits and try root*4+1
		assign sh    = {cur_rem[REM_W-3:0], cur_src[IN_W-1 -: 2]};
		assign trial = REM_W'({cur_root, 2'b01});
		assign ge    = (sh >= trial);
		assign nrem  = ge ? (sh - trial) : sh;
		assign nroot = {cur_root[R_W-2:0], ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k+1] <= 1'b0;
			end else if (en) begin
				vld_r[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_r[k+1] <= nroot;
				side_r[k+1] <= cur_side;
			end
		end

		if (k < R_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_r[k+1] <= nrem;
					src_r[k+1] <= cur_src << 2;
				end
			end
		end
	end

	assign out_valid = vld_r[R_W];
	assign root      = root_r[R_W];
	assign out_side  = side_r[R_W];

endmodule
`default_nettype wire

// ===== sv/lbz_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lbz_div #(
	parameter int DEN_W  = 32,
	parameter int Q_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DEN_W+Q_W-1:0]   dividend,
	input  logic [DEN_W-1:0]       divisor,
	input  logic [SIDE_W-1:0]      in_side,
	output logic                   out_valid,
	output logic [Q_W-1:0]         quotient,
	output logic [SIDE_W-1:0]      out_side
);

	localparam int ACC_W = DEN_W + Q_W;

	logic [ACC_W-1:0]  acc_r  [1:Q_W-1];
	logic [DEN_W-1:0]  den_r  [1:Q_W-1];
	logic [SIDE_W-1:0] side_r [1:Q_W];
	logic              vld_r  [1:Q_W];
	logic [Q_W-1:0]    q_r;

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [ACC_W-1:0]  cur_acc;
		logic [DEN_W-1:0]  cur_den;
		logic [SIDE_W-1:0] cur_side;
		logic              cur_vld;
		logic [DEN_W:0]    top;
		logic [DEN_W:0]    sub;
		logic              ge;
		logic [DEN_W-1:0]  nrem;
		logic [ACC_W-1:0]  nacc;

		if (k == 0) begin : g_first
			assign cur_acc  = dividend;
			assign cur_den  = divisor;
			assign cur_side = in_side;
			assign cur_vld  = in_valid;
		end else begin : g_next
			assign cur_acc  = acc_r[k];
			assign cur_den  = den_r[k];
			assign cur_side = side_r[k];
			assign cur_vld  = vld_r[k];
		end

		// partial remainder with the next dividend bit shifted in
		assign top  = cur_acc[ACC_W-1:Q_W-1];
		assign sub  = top - {1'b0, cur_den};
		assign ge   = (top >= {1'b0, cur_den});
		assign nrem = ge ? sub[DEN_W-1:0] : top[DEN_W-1:0];
		assign nacc = {nrem, cur_acc[Q_W-2:0], ge};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_r[k+1] <= 1'b0;
			end else if (en) begin
				vld_r[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_r[k+1] <= cur_side;
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					acc_r[k+1] <= nacc;
					den_r[k+1] <= cur_den;
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					q_r <= nacc[Q_W-1:0];
				end
			end
		end
	end

	assign out_valid = vld_r[Q_W];
	assign quotient  = q_r;
	assign out_side  = side_r[Q_W];

endmodule
`default_nettype wire

// ===== sv/lorentz_boost_z_with_interval_unit.sv =====
// top level: lorentz boost along z with interval length of the input four-vector
// stage order: s1-s5, sqrt and beta*z units, s6-s8, gamma dividers, output register
// throughput: one item per cycle; the square roots and dividers retire one bit per stage
// the whole pipeline advances together and holds only while a finished result is stalled
// reset: all valid bits clear at once, light speed returns to 1.0 in the fixed-point format
// a light speed write takes effect on the next item; write only while the pipeline is empty
`default_nettype none
module lorentz_boost_z_with_interval_unit #(
	parameter int WORD_BITS = lbz_pkg::DEF_WORD_BITS,
	parameter int FRAC_BITS = lbz_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [WORD_BITS-2:0]        cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] time_comp,
	input  logic signed [WORD_BITS-1:0] x_comp,
	input  logic signed [WORD_BITS-1:0] y_comp,
	input  logic signed [WORD_BITS-1:0] z_comp,
	input  logic signed [WORD_BITS-1:0] velocity,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] time_boosted,
	output logic signed [WORD_BITS-1:0] x_out,
	output logic signed [WORD_BITS-1:0] y_out,
	output logic signed [WORD_BITS-1:0] z_boosted,
	output logic [WORD_BITS-2:0]        interval_length,
	output lbz_pkg::kind_t              interval_kind,
	output logic                        speed_error
);

	import lbz_pkg::*;

	localparam int W    = WORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int C_W  = W - 1;                  // light speed
	localparam int W2   = 2 * W;                  // full products
	localparam int CT_W = W2 - F;                 // c*t and v*t after the fraction shift
	localparam int MX_W = (CT_W > W) ? CT_W : W;
	localparam int D_W  = MX_W + 2;               // signed differences before gamma
	localparam int LO_W = D_W / 2;                // split of the gamma product
	localparam int HI_W = D_W - LO_W;
	localparam int P_W  = D_W + C_W;              // |d| * c
	localparam int SS_W = CT_W + 1 + D_W + W + W + 1;
	localparam int TS_W = 1 + 1 + W + W + 1 + C_W + 2;

	// global advance: hold every pipeline stage only while a result waits
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// light speed register
	logic [C_W-1:0] light_speed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_speed_q <= C_W'(1) << F;
		end else if (cfg_wr_en) begin
			light_speed_q <= cfg_wr_data;
		end
	end

	// ---------------- s1: input register
	logic                vld_s1;
	logic signed [W-1:0] t_s1, x_s1, y_s1, z_s1, v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= time_comp;
			x_s1 <= x_comp;
			y_s1 <= y_comp;
			z_s1 <= z_comp;
			v_s1 <= velocity;
		end
	end

	// ---------------- s2: magnitudes, signs, speed check
	logic [W-1:0] tm_c, xm_c, ym_c, zm_c, vm_c;
	logic         err_c;

	assign tm_c  = t_s1[W-1] ? (~t_s1 + 1'b1) : t_s1;
	assign xm_c  = x_s1[W-1] ? (~x_s1 + 1'b1) : x_s1;
	assign ym_c  = y_s1[W-1] ? (~y_s1 + 1'b1) : y_s1;
	assign zm_c  = z_s1[W-1] ? (~z_s1 + 1'b1) : z_s1;
	assign vm_c  = v_s1[W-1] ? (~v_s1 + 1'b1) : v_s1;
	// zero light speed counts as too fast, which keeps the dividers harmless
	assign err_c = (light_speed_q == '0) || (vm_c >= W'(light_speed_q));

	logic                vld_s2, err_s2, t_neg_s2, z_neg_s2, v_neg_s2;
	logic [W-1:0]        tm_s2, xm_s2, ym_s2, zm_s2, vm_s2;
	logic signed [W-1:0] x_s2, y_s2, z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tm_s2    <= tm_c;
			xm_s2    <= xm_c;
			ym_s2    <= ym_c;
			zm_s2    <= zm_c;
			vm_s2    <= vm_c;
			t_neg_s2 <= t_s1[W-1];
			z_neg_s2 <= z_s1[W-1];
			v_neg_s2 <= v_s1[W-1];
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			err_s2   <= err_c;
		end
	end

	// ---------------- s3: one multiplier per product
	logic                vld_s3, err_s3, t_neg_s3, bz_neg_s3, tv_neg_s3;
	logic [W2-1:0]       t2_s3, x2_s3, y2_s3, z2_s3;
	logic [W2-1:0]       ctm_s3, vzm_s3, vtm_s3, vsq_s3, csq_s3;
	logic signed [W-1:0] x_s3, y_s3, z_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s3     <= W2'(tm_s2) * W2'(tm_s2);
			x2_s3     <= W2'(xm_s2) * W2'(xm_s2);
			y2_s3     <= W2'(ym_s2) * W2'(ym_s2);
			z2_s3     <= W2'(zm_s2) * W2'(zm_s2);
			ctm_s3    <= W2'(light_speed_q) * W2'(tm_s2);
			vzm_s3    <= W2'(vm_s2) * W2'(zm_s2);
			vtm_s3    <= W2'(vm_s2) * W2'(tm_s2);
			vsq_s3    <= W2'(vm_s2) * W2'(vm_s2);
			csq_s3    <= W2'(light_speed_q) * W2'(light_speed_q);
			t_neg_s3  <= t_neg_s2;
			bz_neg_s3 <= v_neg_s2 ^ z_neg_s2;
			tv_neg_s3 <= v_neg_s2 ^ t_neg_s2;
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			z_s3      <= z_s2;
			err_s3    <= err_s2;
		end
	end

	// ---------------- s4: r^2 sum, c^2 - v^2, z - beta*c*t
	logic signed [D_W-1:0] z_x, vt_x, dz_c;

	assign z_x  = {{(D_W-W){z_s3[W-1]}}, z_s3};
	assign vt_x = $signed({{(D_W-CT_W){1'b0}}, vtm_s3[W2-1:F]});
	assign dz_c = tv_neg_s3 ? (z_x + vt_x) : (z_x - vt_x);

	logic                  vld_s4, err_s4, t_neg_s4, bz_neg_s4;
	logic [W2-1:0]         t2_s4, r2_s4, d2_s4, vzm_s4;
	logic [CT_W-1:0]       ct_m_s4;
	logic signed [D_W-1:0] dz_s4;
	logic signed [W-1:0]   x_s4, y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s4     <= t2_s3;
			r2_s4     <= x2_s3 + y2_s3 + z2_s3;
			d2_s4     <= csq_s3 - vsq_s3;
			vzm_s4    <= vzm_s3;
			ct_m_s4   <= ctm_s3[W2-1:F];
			t_neg_s4  <= t_neg_s3;
			bz_neg_s4 <= bz_neg_s3;
			dz_s4     <= dz_c;
			x_s4      <= x_s3;
			y_s4      <= y_s3;
			err_s4    <= err_s3;
		end
	end

	// ---------------- s5: interval class and |t^2 - r^2|
	kind_t         kind_c;
	logic [W2-1:0] diff_c;

	always_comb begin
		if (t2_s4 > r2_s4) begin
			kind_c = KIND_TIMELIKE;
			diff_c = t2_s4 - r2_s4;
		end else if (t2_s4 == r2_s4) begin
			kind_c = KIND_LIGHTLIKE;
			diff_c = '0;
		end else begin
			kind_c = KIND_SPACELIKE;
			diff_c = r2_s4 - t2_s4;
		end
	end

	logic                  vld_s5, err_s5, t_neg_s5, bz_neg_s5;
	kind_t                 kind_s5;
	logic [W2-1:0]         diff_s5, d2_s5, vzm_s5;
	logic [CT_W-1:0]       ct_m_s5;
	logic signed [D_W-1:0] dz_s5;
	logic signed [W-1:0]   x_s5, y_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5   <= kind_c;
			diff_s5   <= diff_c;
			d2_s5     <= d2_s4;
			vzm_s5    <= vzm_s4;
			ct_m_s5   <= ct_m_s4;
			t_neg_s5  <= t_neg_s4;
			bz_neg_s5 <= bz_neg_s4;
			dz_s5     <= dz_s4;
			x_s5      <= x_s4;
			y_s5      <= y_s4;
			err_s5    <= err_s4;
		end
	end

	// ---------------- three bit-serial pipelines of equal length
	// interval length, gamma denominator sqrt(c^2 - v^2), and v*z/c
	logic          len_vld, s_vld, bz_vld;
	logic [W-1:0]  len_root, s_root, bz_q;
	kind_t         len_kind;
	logic [SS_W-1:0] s_side;
	logic          bz_neg_u;

	lbz_isqrt #(.R_W(W), .SIDE_W(2)) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.radicand  (diff_s5),
		.in_side   (kind_s5),
		.out_valid (len_vld),
		.root      (len_root),
		.out_side  (len_kind)
	);

	lbz_isqrt #(.R_W(W), .SIDE_W(SS_W)) u_gam_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.radicand  (d2_s5),
		.in_side   ({ct_m_s5, t_neg_s5, dz_s5, x_s5, y_s5, err_s5}),
		.out_valid (s_vld),
		.root      (s_root),
		.out_side  (s_side)
	);

	lbz_div #(.DEN_W(W), .Q_W(W), .SIDE_W(1)) u_bz_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.dividend  (vzm_s5),
		.divisor   (W'(light_speed_q)),
		.in_side   (bz_neg_s5),
		.out_valid (bz_vld),
		.quotient  (bz_q),
		.out_side  (bz_neg_u)
	);

	logic [CT_W-1:0]       ct_m_u;
	logic                  t_neg_u, err_u;
	logic signed [D_W-1:0] dz_u;
	logic signed [W-1:0]   x_u, y_u;

	assign {ct_m_u, t_neg_u, dz_u, x_u, y_u, err_u} = s_side;

	// ---------------- s6: c*t - beta*z, interval saturation
	logic signed [D_W-1:0] ct_x, bz_x, ct_v, dt_c;
	logic [C_W-1:0]        len_sat_c;

	assign ct_x      = $signed({{(D_W-CT_W){1'b0}}, ct_m_u});
	assign bz_x      = $signed({{(D_W-W){1'b0}}, bz_q});
	assign ct_v      = t_neg_u ? -ct_x : ct_x;
	assign dt_c      = bz_neg_u ? (ct_v + bz_x) : (ct_v - bz_x);
	assign len_sat_c = len_root[W-1] ? {C_W{1'b1}} : len_root[W-2:0];

	logic                  vld_s6, err_s6;
	logic signed [D_W-1:0] dt_s6, dz_s6;
	logic [W-1:0]          s_s6;
	logic [C_W-1:0]        len_s6;
	kind_t                 kind_s6;
	logic signed [W-1:0]   x_s6, y_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= len_vld & s_vld & bz_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dt_s6   <= dt_c;
			dz_s6   <= dz_u;
			s_s6    <= s_root;
			len_s6  <= len_sat_c;
			kind_s6 <= len_kind;
			x_s6    <= x_u;
			y_s6    <= y_u;
			err_s6  <= err_u;
		end
	end

	// ---------------- s7: |d| * c as two partial products
	logic [D_W-1:0] dtm_c, dzm_c;

	assign dtm_c = dt_s6[D_W-1] ? D_W'(-dt_s6) : D_W'(dt_s6);
	assign dzm_c = dz_s6[D_W-1] ? D_W'(-dz_s6) : D_W'(dz_s6);

	logic                    vld_s7, err_s7, t_neg_s7, z_neg_s7;
	logic [LO_W+C_W-1:0]     pt_lo_s7, pz_lo_s7;
	logic [HI_W+C_W-1:0]     pt_hi_s7, pz_hi_s7;
	logic [W-1:0]            s_s7;
	logic [C_W-1:0]          len_s7;
	kind_t                   kind_s7;
	logic signed [W-1:0]     x_s7, y_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_lo_s7 <= (LO_W+C_W)'(dtm_c[LO_W-1:0]) * (LO_W+C_W)'(light_speed_q);
			pt_hi_s7 <= (HI_W+C_W)'(dtm_c[D_W-1:LO_W]) * (HI_W+C_W)'(light_speed_q);
			pz_lo_s7 <= (LO_W+C_W)'(dzm_c[LO_W-1:0]) * (LO_W+C_W)'(light_speed_q);
			pz_hi_s7 <= (HI_W+C_W)'(dzm_c[D_W-1:LO_W]) * (HI_W+C_W)'(light_speed_q);
			t_neg_s7 <= dt_s6[D_W-1];
			z_neg_s7 <= dz_s6[D_W-1];
			s_s7     <= s_s6;
			len_s7   <= len_s6;
			kind_s7  <= kind_s6;
			x_s7     <= x_s6;
			y_s7     <= y_s6;
			err_s7   <= err_s6;
		end
	end

	// ---------------- s8: full product, quotient overflow check
	logic [P_W-1:0] pt_c, pz_c;
	logic           over_t_c, over_z_c;

	assign pt_c     = (P_W'(pt_hi_s7) << LO_W) + P_W'(pt_lo_s7);
	assign pz_c     = (P_W'(pz_hi_s7) << LO_W) + P_W'(pz_lo_s7);
	// a quotient that needs more than a word saturates anyway
	assign over_t_c = (pt_c >> W) >= P_W'(s_s7);
	assign over_z_c = (pz_c >> W) >= P_W'(s_s7);

	logic                vld_s8, err_s8, t_neg_s8, z_neg_s8, over_t_s8, over_z_s8;
	logic [W2-1:0]       nt_s8, nz_s8;
	logic [W-1:0]        s_s8;
	logic [C_W-1:0]      len_s8;
	kind_t               kind_s8;
	logic signed [W-1:0] x_s8, y_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nt_s8     <= pt_c[W2-1:0];
			nz_s8     <= pz_c[W2-1:0];
			over_t_s8 <= over_t_c;
			over_z_s8 <= over_z_c;
			t_neg_s8  <= t_neg_s7;
			z_neg_s8  <= z_neg_s7;
			s_s8      <= s_s7;
			len_s8    <= len_s7;
			kind_s8   <= kind_s7;
			x_s8      <= x_s7;
			y_s8      <= y_s7;
			err_s8    <= err_s7;
		end
	end

	// ---------------- gamma division for t' and z'
	logic              tq_vld, zq_vld;
	logic [W-1:0]      tq, zq;
	logic [TS_W-1:0]   t_side;
	logic [1:0]        z_side;

	lbz_div #(.DEN_W(W), .Q_W(W), .SIDE_W(TS_W)) u_t_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s8),
		.dividend  (nt_s8),
		.divisor   (s_s8),
		.in_side   ({t_neg_s8, over_t_s8, x_s8, y_s8, err_s8, len_s8, kind_s8}),
		.out_valid (tq_vld),
		.quotient  (tq),
		.out_side  (t_side)
	);

	lbz_div #(.DEN_W(W), .Q_W(W), .SIDE_W(2)) u_z_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s8),
		.dividend  (nz_s8),
		.divisor   (s_s8),
		.in_side   ({z_neg_s8, over_z_s8}),
		.out_valid (zq_vld),
		.quotient  (zq),
		.out_side  (z_side)
	);

	logic                t_neg_d, over_t_d, err_d, z_neg_d, over_z_d;
	logic signed [W-1:0] x_d, y_d;
	logic [C_W-1:0]      len_d;
	kind_t               kind_d;

	assign {t_neg_d, over_t_d, x_d, y_d, err_d, len_d, kind_d} = t_side;
	assign {z_neg_d, over_z_d} = z_side;

	// ---------------- output register: sign, saturation, speed error
	logic [W-1:0] t_sat_c, z_sat_c;
	logic [W-1:0] max_pos, min_neg;

	assign max_pos = {1'b0, {(W-1){1'b1}}};
	assign min_neg = {1'b1, {(W-1){1'b0}}};

	always_comb begin
		if (t_neg_d) begin
			t_sat_c = (over_t_d || tq[W-1]) ? min_neg : (~tq + 1'b1);
		end else begin
			t_sat_c = (over_t_d || tq[W-1]) ? max_pos : tq;
		end
		if (z_neg_d) begin
			z_sat_c = (over_z_d || zq[W-1]) ? min_neg : (~zq + 1'b1);
		end else begin
			z_sat_c = (over_z_d || zq[W-1]) ? max_pos : zq;
		end
	end

	logic                out_valid_q;
	logic signed [W-1:0] t_out_q, x_out_q, y_out_q, z_out_q;
	logic [C_W-1:0]      len_q;
	kind_t               kind_q;
	logic                err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tq_vld & zq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_out_q <= err_d ? '0 : $signed(t_sat_c);
			z_out_q <= err_d ? '0 : $signed(z_sat_c);
			x_out_q <= err_d ? '0 : x_d;
			y_out_q <= err_d ? '0 : y_d;
			len_q   <= len_d;
			kind_q  <= kind_d;
			err_q   <= err_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign time_boosted    = t_out_q;
	assign x_out           = x_out_q;
	assign y_out           = y_out_q;
	assign z_boosted       = z_out_q;
	assign interval_length = len_q;
	assign interval_kind   = kind_q;
	assign speed_error     = err_q;

`ifndef SYNTH
	a_unit_align: assert property (@(posedge clk) disable iff (!arst_n)
		(len_vld == s_vld) && (s_vld == bz_vld))
		else $error("sqrt and divider pipelines out of step");

	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		tq_vld == zq_vld)
		else $error("t and z gamma dividers out of step");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && speed_error) |->
		(time_boosted == '0) && (z_boosted == '0) && (x_out == '0) && (y_out == '0))
		else $error("speed error item with nonzero boosted fields");

	a_light_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (interval_kind == KIND_LIGHTLIKE)) |-> (interval_length == '0))
		else $error("lightlike item with nonzero interval length");
`endif

endmodule
`default_nettype wire
